// File: rtl/epr_pkg.sv
`default_nettype none
package epr_pkg;

	localparam int FRAC_BITS_DEF    = 16;
	localparam int CORDIC_STEPS_DEF = 18;

	localparam longint Q30_PI         = 64'sd3373259426;
	localparam longint Q30_HALF_PI    = 64'sd1686629713;
	localparam longint Q30_TWO_PI     = 64'sd6746518852;
	localparam longint Q30_QUARTER_PI = 64'sd843314857;
	localparam longint Q30_GAIN       = 64'sd652032874;

	localparam int ZW = 34;

	localparam logic [2:0] REG_AXIS_A   = 3'd0;
	localparam logic [2:0] REG_AXIS_B   = 3'd1;
	localparam logic [2:0] REG_CENTRE_X = 3'd2;
	localparam logic [2:0] REG_CENTRE_Y = 3'd3;
	localparam logic [2:0] REG_ROTATION = 3'd4;

	typedef struct packed {
		logic signed [ZW-1:0] x;
		logic signed [ZW-1:0] y;
		logic signed [ZW-1:0] z;
		logic                 flip;
	} cordic_t;

	// restoring division, elaboration use only
	function automatic longint unsigned udiv64(longint unsigned n, longint unsigned d);
		longint unsigned qq;
		longint unsigned rr;
		qq = '0;
		rr = '0;
		for (int k = 63; k >= 0; k--) begin
			rr = {rr[62:0], n[k]};
			if (rr >= d) begin
				rr = rr - d;
				qq[k] = 1'b1;
			end
		end
		return qq;
	endfunction

	// arctan(2^-i) in Q30 from the series in Q60
	function automatic longint atan_q30(int i);
		longint acc;
		longint term;
		int     e;
		acc = 0;
		if (i == 0) return Q30_QUARTER_PI;
		for (int k = 0; k < 32; k++) begin
			e = 60 - i * (2 * k + 1);
			if (e >= 0) begin
				term = longint'(udiv64(64'd1 << e, longint'(2 * k + 1)));
				acc = (k % 2 == 1) ? acc - term : acc + term;
			end
		end
		return (acc + (64'sd1 <<< 29)) >>> 30;
	endfunction

	function automatic logic signed [31:0] sat32(logic signed [35:0] v);
		if (v > 36'sd2147483647) return 32'sh7fffffff;
		if (v < -36'sd2147483648) return 32'sh80000000;
		return v[31:0];
	endfunction

endpackage
`default_nettype wire

// File: rtl/epr_reduce.sv
`default_nettype none
module epr_reduce #(
	parameter int FRAC_BITS = epr_pkg::FRAC_BITS_DEF
) (
	input  wire logic                 clk,
	input  wire logic signed [20:0]   ang,
	output epr_pkg::cordic_t          cell_out
);
	localparam int SH = 30 - FRAC_BITS;
	// turns per input LSB, scaled by 2^40
	localparam logic [30:0] RECIP =
		31'((64'd1 << (70 - FRAC_BITS)) / 64'd6746518852);
	localparam logic signed [35:0] PI36    = 36'(epr_pkg::Q30_PI);
	localparam logic signed [35:0] HALF36  = 36'(epr_pkg::Q30_HALF_PI);
	localparam logic signed [35:0] TWOPI36 = 36'(epr_pkg::Q30_TWO_PI);

	logic signed [52:0] prod_s1;
	logic signed [20:0] ang_s1;
	logic signed [35:0] rem_s2;
	logic signed [35:0] m_s3;

	logic signed [12:0] q;
	logic signed [63:0] zl;
	logic signed [63:0] rem;
	logic signed [35:0] m;
	logic signed [35:0] zc;
	logic signed [35:0] zz;
	logic               fl;

	always_comb begin
		q   = 13'(prod_s1 >>> 40);
		zl  = 64'(ang_s1) <<< SH;
		rem = zl - 64'(q) * epr_pkg::Q30_TWO_PI;
		// estimated turn count may be one off either way
		if (rem_s2 < 0)
			m = rem_s2 + TWOPI36;
		else if (rem_s2 >= TWOPI36)
			m = rem_s2 - TWOPI36;
		else
			m = rem_s2;
		zc = (m_s3 > PI36) ? m_s3 - TWOPI36 : m_s3;
		fl = 1'b0;
		zz = zc;
		if (zc > HALF36) begin
			zz = zc - PI36;
			fl = 1'b1;
		end else if (zc < -HALF36) begin
			zz = zc + PI36;
			fl = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1       <= 53'(ang) * 53'($signed({1'b0, RECIP}));
		ang_s1        <= ang;
		rem_s2        <= 36'(rem);
		m_s3          <= m;
		cell_out.x    <= epr_pkg::ZW'(epr_pkg::Q30_GAIN);
		cell_out.y    <= '0;
		cell_out.z    <= epr_pkg::ZW'(zz);
		cell_out.flip <= fl;
	end
endmodule
`default_nettype wire

// File: rtl/epr_cordic_cell.sv
`default_nettype none
module epr_cordic_cell #(
	parameter int STEP = 0
) (
	input  wire logic        clk,
	input  epr_pkg::cordic_t cell_in,
	output epr_pkg::cordic_t cell_out
);
	localparam longint AT = epr_pkg::atan_q30(STEP);

	logic signed [epr_pkg::ZW-1:0] dx;
	logic signed [epr_pkg::ZW-1:0] dy;

	assign dx = cell_in.y >>> STEP;
	assign dy = cell_in.x >>> STEP;

	always_ff @(posedge clk) begin
		cell_out.flip <= cell_in.flip;
		if (cell_in.z >= 0) begin
			cell_out.x <= cell_in.x - dx;
			cell_out.y <= cell_in.y + dy;
			cell_out.z <= cell_in.z - epr_pkg::ZW'(AT);
		end else begin
			cell_out.x <= cell_in.x + dx;
			cell_out.y <= cell_in.y - dy;
			cell_out.z <= cell_in.z + epr_pkg::ZW'(AT);
		end
	end
endmodule
`default_nettype wire

// File: rtl/ellipse_point_residual_jacobian.sv
`default_nettype none
// Ellipse residual and Jacobian pipeline. One point is taken every cycle (busy is
// always low). Its result is registered after four angle-reduction stages, one
// CORDIC cell per step and five sign, multiply, sum and saturate stages, and sits
// on the output ports, marked by done, for one cycle. Results cannot be held off,
// so the receiver must take each one as it comes. Registers may only be written
// while no point is in flight.
module ellipse_point_residual_jacobian #(
	parameter int FRAC_BITS    = epr_pkg::FRAC_BITS_DEF,
	parameter int CORDIC_STEPS = epr_pkg::CORDIC_STEPS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [4:0]         paddr,
	input  wire logic [31:0]        pwdata,
	output logic      [31:0]        prdata,
	output logic                    pready,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic signed [31:0] point_x,
	input  wire logic signed [31:0] point_y,
	input  wire logic signed [20:0] curve_t,
	output logic                    done,
	output logic signed [31:0]      res_x,
	output logic signed [31:0]      res_y,
	output logic signed [31:0]      jx_t,
	output logic signed [31:0]      jy_t,
	output logic signed [17:0]      jx_a,
	output logic signed [17:0]      jx_b,
	output logic signed [31:0]      jx_r,
	output logic signed [17:0]      jy_a,
	output logic signed [17:0]      jy_b,
	output logic signed [31:0]      jy_r
);
	localparam int DLY = CORDIC_STEPS + 8;
	localparam logic signed [33:0] ONE = 34'(64'sd1 <<< FRAC_BITS);
	localparam logic signed [63:0] H30 = 64'sd1 <<< 29;

	logic signed [31:0] axis_a_q, axis_b_q, centre_x_q, centre_y_q;
	logic signed [20:0] rotation_q;
	logic [2:0]         idx;

	assign idx    = paddr[4:2];
	assign pready = 1'b1;
	assign busy   = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			axis_a_q   <= '0;
			axis_b_q   <= '0;
			centre_x_q <= '0;
			centre_y_q <= '0;
			rotation_q <= '0;
		end else if (psel && penable && pwrite) begin
			case (idx)
				epr_pkg::REG_AXIS_A:   axis_a_q   <= pwdata;
				epr_pkg::REG_AXIS_B:   axis_b_q   <= pwdata;
				epr_pkg::REG_CENTRE_X: centre_x_q <= pwdata;
				epr_pkg::REG_CENTRE_Y: centre_y_q <= pwdata;
				epr_pkg::REG_ROTATION: rotation_q <= pwdata[20:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			epr_pkg::REG_AXIS_A:   prdata = axis_a_q;
			epr_pkg::REG_AXIS_B:   prdata = axis_b_q;
			epr_pkg::REG_CENTRE_X: prdata = centre_x_q;
			epr_pkg::REG_CENTRE_Y: prdata = centre_y_q;
			epr_pkg::REG_ROTATION: prdata = {11'd0, rotation_q};
			default:               prdata = '0;
		endcase
	end

	// two CORDIC rows: curve angle and rotation
	epr_pkg::cordic_t chain_t [0:CORDIC_STEPS];
	epr_pkg::cordic_t chain_r [0:CORDIC_STEPS];

	epr_reduce #(.FRAC_BITS(FRAC_BITS)) u_red_t (
		.clk(clk), .ang(curve_t), .cell_out(chain_t[0]));
	epr_reduce #(.FRAC_BITS(FRAC_BITS)) u_red_r (
		.clk(clk), .ang(rotation_q), .cell_out(chain_r[0]));

	for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cell
		epr_cordic_cell #(.STEP(g)) u_ct (
			.clk(clk), .cell_in(chain_t[g]), .cell_out(chain_t[g+1]));
		epr_cordic_cell #(.STEP(g)) u_cr (
			.clk(clk), .cell_in(chain_r[g]), .cell_out(chain_r[g+1]));
	end

	logic               vld_q [0:DLY];
	logic signed [31:0] px_q  [0:DLY-1];
	logic signed [31:0] py_q  [0:DLY-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= DLY; k++) vld_q[k] <= 1'b0;
		end else begin
			vld_q[0] <= start;
			for (int k = 1; k <= DLY; k++) vld_q[k] <= vld_q[k-1];
		end
	end

	always_ff @(posedge clk) begin
		px_q[0] <= point_x;
		py_q[0] <= point_y;
		for (int k = 1; k < DLY; k++) begin
			px_q[k] <= px_q[k-1];
			py_q[k] <= py_q[k-1];
		end
	end

	function automatic logic signed [17:0] unit_clamp(logic signed [31:0] p);
		logic signed [33:0] v;
		v = (-34'(p) + (34'sd1 <<< (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
		if (v > ONE) v = ONE;
		if (v < -ONE) v = -ONE;
		if (v > 34'sd131071) v = 34'sd131071;
		if (v < -34'sd131072) v = -34'sd131072;
		return v[17:0];
	endfunction

	function automatic logic signed [31:0] rnd30(logic signed [63:0] p);
		return 32'((p + H30) >>> 30);
	endfunction

	logic signed [31:0] ct_s1, st_s1, cr_s1, sr_s1;
	logic signed [31:0] cc_s2, cs_s2, sc_s2, ss_s2;
	logic signed [63:0] acc_s3, bss_s3, acs_s3, bsc_s3, asc_s3, bcs_s3, ass_s3, bcc_s3;
	logic signed [17:0] ua_x_s3, ub_x_s3, ua_y_s3, ub_y_s3;
	logic signed [33:0] ex_s4, ey_s4, jxt_s4, jyt_s4, jyr_s4;
	logic signed [17:0] ua_x_s4, ub_x_s4, ua_y_s4, ub_y_s4;

	epr_pkg::cordic_t lt, lr;
	assign lt = chain_t[CORDIC_STEPS];
	assign lr = chain_r[CORDIC_STEPS];

	always_ff @(posedge clk) begin
		ct_s1 <= lt.flip ? -lt.x[31:0] : lt.x[31:0];
		st_s1 <= lt.flip ? -lt.y[31:0] : lt.y[31:0];
		cr_s1 <= lr.flip ? -lr.x[31:0] : lr.x[31:0];
		sr_s1 <= lr.flip ? -lr.y[31:0] : lr.y[31:0];

		cc_s2 <= rnd30(64'(ct_s1) * 64'(cr_s1));
		cs_s2 <= rnd30(64'(ct_s1) * 64'(sr_s1));
		sc_s2 <= rnd30(64'(st_s1) * 64'(cr_s1));
		ss_s2 <= rnd30(64'(st_s1) * 64'(sr_s1));

		acc_s3  <= 64'(axis_a_q) * 64'(cc_s2);
		bss_s3  <= 64'(axis_b_q) * 64'(ss_s2);
		acs_s3  <= 64'(axis_a_q) * 64'(cs_s2);
		bsc_s3  <= 64'(axis_b_q) * 64'(sc_s2);
		asc_s3  <= 64'(axis_a_q) * 64'(sc_s2);
		bcs_s3  <= 64'(axis_b_q) * 64'(cs_s2);
		ass_s3  <= 64'(axis_a_q) * 64'(ss_s2);
		bcc_s3  <= 64'(axis_b_q) * 64'(cc_s2);
		ua_x_s3 <= unit_clamp(cc_s2);
		ub_x_s3 <= unit_clamp(-ss_s2);
		ua_y_s3 <= unit_clamp(cs_s2);
		ub_y_s3 <= unit_clamp(sc_s2);

		// jy_r rounds the negated sum, not a negated ex
		ex_s4   <= 34'((acc_s3 - bss_s3 + H30) >>> 30);
		ey_s4   <= 34'((acs_s3 + bsc_s3 + H30) >>> 30);
		jxt_s4  <= 34'((asc_s3 + bcs_s3 + H30) >>> 30);
		jyt_s4  <= 34'((ass_s3 - bcc_s3 + H30) >>> 30);
		jyr_s4  <= 34'((bss_s3 - acc_s3 + H30) >>> 30);
		ua_x_s4 <= ua_x_s3;
		ub_x_s4 <= ub_x_s3;
		ua_y_s4 <= ua_y_s3;
		ub_y_s4 <= ub_y_s3;

		res_x <= epr_pkg::sat32(36'(px_q[DLY-1]) - 36'(centre_x_q) - 36'(ex_s4));
		res_y <= epr_pkg::sat32(36'(py_q[DLY-1]) - 36'(centre_y_q) - 36'(ey_s4));
		jx_t  <= epr_pkg::sat32(36'(jxt_s4));
		jy_t  <= epr_pkg::sat32(36'(jyt_s4));
		jx_r  <= epr_pkg::sat32(36'(ey_s4));
		jy_r  <= epr_pkg::sat32(36'(jyr_s4));
		jx_a  <= ua_x_s4;
		jx_b  <= ub_x_s4;
		jy_a  <= ua_y_s4;
		jy_b  <= ub_y_s4;
	end

	assign done = vld_q[DLY];

`ifndef SYNTHESIS
	a_done_follows_start: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, DLY + 1))
		else $error("result strobe without matching transfer");
	a_unit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (34'(jx_a) <= ONE && 34'(jx_a) >= -ONE &&
		          34'(jy_b) <= ONE && 34'(jy_b) >= -ONE))
		else $error("unit Jacobian entry out of range");
`endif
endmodule
`default_nettype wire
